// File: rtl/core/annexb_pkg.sv
package annexb_pkg;

    // Width of the internal stream counters.
    localparam int COUNT_WIDTH = 24;

    // Width of the configuration register and of the result fields.
    localparam int OUT_WIDTH = 24;

    // Width used to compare an IDR count against the configured index.
    localparam int CMP_WIDTH = (COUNT_WIDTH > OUT_WIDTH) ? COUNT_WIDTH : OUT_WIDTH;

    // NAL header decoding.
    localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
    localparam logic [4:0] NAL_TYPE_IDR  = 5'd5;
    localparam logic [4:0] NAL_TYPE_MIN  = 5'd1;

    // Start code patterns as seen in the byte window, newest byte lowest.
    localparam logic [23:0] START_CODE_3 = 24'h000001;
    localparam logic [31:0] START_CODE_4 = 32'h00000001;
    localparam logic [31:0] WINDOW_IDLE  = 32'hFFFFFFFF;

    // Distance from the last header, saturating at four bytes.
    localparam int          GAP_WIDTH = 3;
    localparam logic [2:0]  GAP_MAX   = 3'd4;
    localparam logic [2:0]  GAP_SHORT = 3'd3;

    // Saturated counter value.
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

endpackage

// File: rtl/core/annexb_stream_if.sv
// Input channel: one byte of the stream per transaction.
interface annexb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// Output channel: one summary per stream.
interface annexb_out_if;
    logic                             valid;
    logic                             ready;
    logic [annexb_pkg::OUT_WIDTH-1:0] slice_count;
    logic [annexb_pkg::OUT_WIDTH-1:0] idr_count;
    logic [annexb_pkg::OUT_WIDTH-1:0] target_frame_number;

    modport source (output valid, output slice_count, output idr_count,
                    output target_frame_number, input ready);
    modport sink   (input valid, input slice_count, input idr_count,
                    input target_frame_number, output ready);
endinterface

// File: rtl/core/annexb_slice_and_idr_counter_core.sv
// A final byte is registered in the input stage, and its result is then registered in the result stage.
// Throughput: one byte per cycle while the input is not stalled, with one window and counter update per byte.
// A final byte waits in the input register while the previous result is still held;
// that is the only stall the result channel puts on the input.
// Reset (rst_n low, asynchronous) empties both stages, sets the window to all ones,
// clears the counters and sets the IDR index register to zero.
module annexb_slice_and_idr_counter_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [annexb_pkg::OUT_WIDTH-1:0] cfg_write_data,
    annexb_in_if.sink                        in_chan,
    annexb_out_if.source                     out_chan
);

    // Configuration register.
    logic [annexb_pkg::OUT_WIDTH-1:0] idr_target_reg;

    // Input stage.
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;
    logic       advance;

    // Stream state.
    logic [31:0]                        window_reg;
    logic [annexb_pkg::GAP_WIDTH-1:0]   gap_reg;
    logic [annexb_pkg::COUNT_WIDTH-1:0] slices_reg;
    logic [annexb_pkg::COUNT_WIDTH-1:0] idrs_reg;
    logic [annexb_pkg::COUNT_WIDTH-1:0] found_reg;
    logic                               target_found_reg;

    logic [31:0]                        window_next;
    logic [annexb_pkg::GAP_WIDTH-1:0]   gap_next;
    logic [annexb_pkg::COUNT_WIDTH-1:0] slices_next;
    logic [annexb_pkg::COUNT_WIDTH-1:0] idrs_next;
    logic [annexb_pkg::COUNT_WIDTH-1:0] found_next;
    logic                               target_found_next;

    // Result stage.
    logic                             out_vld_reg;
    logic [annexb_pkg::OUT_WIDTH-1:0] slice_count_reg;
    logic [annexb_pkg::OUT_WIDTH-1:0] idr_count_reg;
    logic [annexb_pkg::OUT_WIDTH-1:0] target_frame_reg;

    // Header decode.
    logic       hit;
    logic [4:0] nal_type;
    logic       is_slice;
    logic       is_idr;
    logic       target_match;

    // Configuration write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idr_target_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            idr_target_reg <= cfg_write_data;
        end
    end

    // The input stage moves on unless it holds a final byte and the result is blocked.
    assign advance       = in_vld_reg && (!in_eos_reg || !out_vld_reg || out_chan.ready);
    assign in_chan.ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_chan.ready)
        begin
            in_vld_reg <= in_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_chan.ready && in_chan.valid)
        begin
            in_byte_reg <= in_chan.data_byte;
            in_eos_reg  <= in_chan.end_of_stream;
        end
    end

    // Start code detection; on the final byte only the four-byte form counts.
    always_comb
    begin
        if (in_eos_reg)
        begin
            hit = (window_reg == annexb_pkg::START_CODE_4) && (gap_reg >= annexb_pkg::GAP_MAX);
        end
        else
        begin
            hit = (window_reg[23:0] == annexb_pkg::START_CODE_3)
                  && (gap_reg >= annexb_pkg::GAP_SHORT);
        end
    end

    assign nal_type     = in_byte_reg[4:0] & annexb_pkg::NAL_TYPE_MASK;
    assign is_slice     = hit && (nal_type >= annexb_pkg::NAL_TYPE_MIN)
                          && (nal_type <= annexb_pkg::NAL_TYPE_IDR);
    assign is_idr       = hit && (nal_type == annexb_pkg::NAL_TYPE_IDR);
    assign target_match = annexb_pkg::CMP_WIDTH'(idrs_reg)
                          == annexb_pkg::CMP_WIDTH'(idr_target_reg);

    // Counter and window update for one byte.
    always_comb
    begin
        slices_next       = slices_reg;
        idrs_next         = idrs_reg;
        found_next        = found_reg;
        target_found_next = target_found_reg;

        if (is_slice && (slices_reg != annexb_pkg::COUNT_MAX))
        begin
            slices_next = slices_reg + 1'b1;
        end
        if (is_idr)
        begin
            if (!target_found_reg && target_match)
            begin
                found_next        = slices_next;
                target_found_next = 1'b1;
            end
            if (idrs_reg != annexb_pkg::COUNT_MAX)
            begin
                idrs_next = idrs_reg + 1'b1;
            end
        end

        if (hit)
        begin
            gap_next = annexb_pkg::GAP_WIDTH'(1);
        end
        else if (gap_reg < annexb_pkg::GAP_MAX)
        begin
            gap_next = gap_reg + 1'b1;
        end
        else
        begin
            gap_next = gap_reg;
        end

        window_next = {window_reg[23:0], in_byte_reg};
    end

    // Stream state registers; cleared after the final byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg       <= annexb_pkg::WINDOW_IDLE;
            gap_reg          <= '0;
            slices_reg       <= '0;
            idrs_reg         <= '0;
            found_reg        <= '0;
            target_found_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (in_eos_reg)
            begin
                window_reg       <= annexb_pkg::WINDOW_IDLE;
                gap_reg          <= '0;
                slices_reg       <= '0;
                idrs_reg         <= '0;
                found_reg        <= '0;
                target_found_reg <= 1'b0;
            end
            else
            begin
                window_reg       <= window_next;
                gap_reg          <= gap_next;
                slices_reg       <= slices_next;
                idrs_reg         <= idrs_next;
                found_reg        <= found_next;
                target_found_reg <= target_found_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance && in_eos_reg)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_chan.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_eos_reg)
        begin
            slice_count_reg  <= annexb_pkg::OUT_WIDTH'(slices_next);
            idr_count_reg    <= annexb_pkg::OUT_WIDTH'(idrs_next);
            target_frame_reg <= target_found_next ? annexb_pkg::OUT_WIDTH'(found_next) : '0;
        end
    end

    assign out_chan.valid               = out_vld_reg;
    assign out_chan.slice_count         = slice_count_reg;
    assign out_chan.idr_count           = idr_count_reg;
    assign out_chan.target_frame_number = target_frame_reg;

    // A new result only follows a final byte leaving the input stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(in_vld_reg && in_eos_reg))
        else $error("result appeared without a final byte");

    // Every IDR is also a slice, so the IDR count never passes the slice count.
    assert property (@(posedge clk) disable iff (!rst_n)
        idrs_reg <= slices_reg)
        else $error("IDR count exceeds slice count");

    // A latched slice number is nonzero and within the slices seen so far.
    assert property (@(posedge clk) disable iff (!rst_n)
        target_found_reg |-> (found_reg != '0) && (found_reg <= slices_reg))
        else $error("latched slice number out of range");

    // The distance to the last header saturates at four.
    assert property (@(posedge clk) disable iff (!rst_n)
        gap_reg <= annexb_pkg::GAP_MAX)
        else $error("header distance out of range");

    // After a final byte the stream state starts over.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_eos_reg) |=> (slices_reg == '0) && (idrs_reg == '0)
                                    && !target_found_reg
                                    && (window_reg == annexb_pkg::WINDOW_IDLE))
        else $error("stream state not cleared after final byte");

endmodule
